FILE: hdl/rc5_pkg.sv
package rc5_pkg;

  localparam int unsigned ROUNDS_DEF = 12;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned KEY_WORDS  = 4;
  localparam int unsigned LI_W       = 2;
  localparam int unsigned ROT_W      = 5;

  localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e1_5163;
  localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e37_79b9;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

  // item commands
  localparam logic CMD_ENC = 1'b0;
  localparam logic CMD_DEC = 1'b1;

  // key register write towards the key schedule
  typedef struct packed {
    logic             valid;
    logic             high;
    logic [KEY_W-1:0] data;
  } kw_req_t;

  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0]  n);
    logic [2*WORD_W-1:0] t;
    t = {x, x} << n;
    return t[2*WORD_W-1:WORD_W];
  endfunction

  function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                               input logic [ROT_W-1:0]  n);
    logic [2*WORD_W-1:0] t;
    t = {x, x} >> n;
    return t[WORD_W-1:0];
  endfunction

endpackage

FILE: hdl/rc5_block_cipher_top.sv
// RC5-32 block cipher, ROUNDS rounds, 16-byte key. Write the key through the
// configuration channel (index 0: bytes 0..7, index 1: bytes 8..15, byte 0 in
// the low bits); every key write restarts the key expansion, and busy_o stays
// high until the 2*(ROUNDS+1)-word round-key table is ready. After reset the
// table is expanded from the all-zero key. Expansion seeds the table with one
// table write per cycle, then runs its mixing steps round the table's single
// read/write port, each step a write (MIXA) and a read (MIXB).
// An item (cmd_i: 0 encrypt, 1 decrypt, with word_a_i and word_b_i) is taken
// when start_i is high and busy_o is low. The cipher runs one half-round per
// cycle, fetching one round key a cycle from the table; after the last
// half-round done_o pulses for exactly one cycle with out_a_o and out_b_o.
// The receiver cannot stall: capture the result in that cycle. A new item
// may be started in the done_o cycle. Configuration writes are held off
// (cfg_ready_o low) while an item is in flight; writes to indexes other than
// 0 and 1 are dropped. A key write holds off an item offered in the same
// cycle, so that item runs with the new key.
module rc5_block_cipher_top #(
  parameter int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          cmd_i,
  input  logic [rc5_pkg::WORD_W-1:0]    word_a_i,
  input  logic [rc5_pkg::WORD_W-1:0]    word_b_i,
  output logic                          done_o,
  output logic [rc5_pkg::WORD_W-1:0]    out_a_o,
  output logic [rc5_pkg::WORD_W-1:0]    out_b_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rc5_pkg::KEY_W-1:0]     cfg_data_i
);

  localparam int unsigned T  = 2 * (ROUNDS + 1);
  localparam int unsigned AW = $clog2(T);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                        state_q, state_d;
  logic                        cmd_q;
  logic                        done_q;
  logic [AW-1:0]               kidx_q, kidx_d;
  logic [rc5_pkg::WORD_W-1:0]  a_q, b_q, a_d, b_d;

  rc5_pkg::kw_req_t            kw;
  logic                        ks_busy;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [rc5_pkg::WORD_W-1:0]  rkey;

  logic                        accept, first_pair, last_step;
  logic [rc5_pkg::WORD_W-1:0]  a_diff, b_diff;

  // Hold off items while a key write is taken: the table is about to be rebuilt.
  assign busy_o      = (state_q == ST_RUN) || ks_busy || kw.valid;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = start_i && !busy_o;

  // Forward only writes to known key registers.
  always_comb begin
    kw.valid = cfg_valid_i && cfg_ready_o &&
               ((cfg_index_i == rc5_pkg::CFG_KEY_LOW) ||
                (cfg_index_i == rc5_pkg::CFG_KEY_HIGH));
    kw.high  = (cfg_index_i == rc5_pkg::CFG_KEY_HIGH);
    kw.data  = cfg_data_i;
  end

  rc5_key_sched #(
    .ROUNDS (ROUNDS)
  ) u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .kw_i      (kw),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rkey),
    .busy_o    (ks_busy)
  );

  // kidx_q names the round key arriving this cycle. Odd keys update b, even
  // keys update a; keys 0 and 1 are the plain key additions of the cipher.
  assign first_pair = (kidx_q[AW-1:1] == '0);
  assign last_step  = (cmd_q == rc5_pkg::CMD_ENC) ? (kidx_q == AW'(T - 1))
                                                  : (kidx_q == '0);
  assign a_diff     = a_q - rkey;
  assign b_diff     = b_q - rkey;

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    kidx_d  = kidx_q;
    rd_en   = 1'b0;
    rd_addr = kidx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          a_d     = word_a_i;
          b_d     = word_b_i;
          kidx_d  = (cmd_i == rc5_pkg::CMD_ENC) ? '0 : AW'(T - 1);
          rd_en   = 1'b1;
          rd_addr = kidx_d;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cmd_q == rc5_pkg::CMD_ENC) begin
          if (kidx_q[0]) begin
            b_d = (first_pair ? b_q : rc5_pkg::rotl32(b_q ^ a_q, a_q[rc5_pkg::ROT_W-1:0]))
                  + rkey;
          end else begin
            a_d = (first_pair ? a_q : rc5_pkg::rotl32(a_q ^ b_q, b_q[rc5_pkg::ROT_W-1:0]))
                  + rkey;
          end
          kidx_d = kidx_q + AW'(1);
        end else begin
          if (kidx_q[0]) begin
            b_d = first_pair ? b_diff
                             : rc5_pkg::rotr32(b_diff, a_q[rc5_pkg::ROT_W-1:0]) ^ a_q;
          end else begin
            a_d = first_pair ? a_diff
                             : rc5_pkg::rotr32(a_diff, b_q[rc5_pkg::ROT_W-1:0]) ^ b_q;
          end
          kidx_d = kidx_q - AW'(1);
        end
        if (last_step) begin
          state_d = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = kidx_d;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_RUN) && last_step;
    end
  end

  // Payload: hold the block while idle so the result stays on the ports.
  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    b_q    <= b_d;
    kidx_q <= kidx_d;
    if (accept) cmd_q <= cmd_i;
  end

  assign done_o  = done_q;
  assign out_a_o = a_q;
  assign out_b_o = b_q;

endmodule

FILE: hdl/rc5_key_sched.sv
module rc5_key_sched #(
  parameter int unsigned ROUNDS = rc5_pkg::ROUNDS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rc5_pkg::kw_req_t          kw_i,
  input  logic                      rd_en_i,
  input  logic [$clog2(2*(ROUNDS+1))-1:0] rd_addr_i,
  output logic [rc5_pkg::WORD_W-1:0] rd_data_o,
  output logic                      busy_o
);

  localparam int unsigned T      = 2 * (ROUNDS + 1);
  localparam int unsigned AW     = $clog2(T);
  localparam int unsigned PASSES = 3 * ((T > rc5_pkg::KEY_WORDS) ? T : rc5_pkg::KEY_WORDS);
  localparam int unsigned STEP_W = $clog2(PASSES);

  localparam logic [2:0] KS_IDLE = 3'd0;
  localparam logic [2:0] KS_LOAD = 3'd1;
  localparam logic [2:0] KS_INIT = 3'd2;
  localparam logic [2:0] KS_MIXR = 3'd3;
  localparam logic [2:0] KS_MIXA = 3'd4;
  localparam logic [2:0] KS_MIXB = 3'd5;

  logic [2:0]                   state_q, state_d;
  logic [rc5_pkg::KEY_W-1:0]    key_lo_q, key_hi_q;
  logic [rc5_pkg::WORD_W-1:0]   l_q [rc5_pkg::KEY_WORDS];
  logic [rc5_pkg::WORD_W-1:0]   ka_q, kb_q, s_acc_q;
  logic [AW-1:0]                ti_q;
  logic [rc5_pkg::LI_W-1:0]     li_q;
  logic [STEP_W-1:0]            step_q;

  logic [rc5_pkg::WORD_W-1:0]   mem [T];
  logic [rc5_pkg::WORD_W-1:0]   rdata_q;

  logic                         we, re;
  logic [AW-1:0]                waddr, raddr, ti_next;
  logic [rc5_pkg::WORD_W-1:0]   wdata, a_new, b_new, ab_sum;

  assign busy_o    = (state_q != KS_IDLE);
  assign rd_data_o = rdata_q;

  assign ti_next = (ti_q == AW'(T - 1)) ? '0 : ti_q + AW'(1);
  assign ab_sum  = ka_q + kb_q;
  assign a_new   = rc5_pkg::rotl32(rdata_q + ab_sum, rc5_pkg::ROT_W'(3));
  assign b_new   = rc5_pkg::rotl32(l_q[li_q] + ab_sum, ab_sum[rc5_pkg::ROT_W-1:0]);

  // The table entry rewritten in MIXA is never the one read in the following
  // MIXB, so read and write never meet on one entry.
  always_comb begin
    state_d = state_q;
    we      = 1'b0;
    waddr   = ti_q;
    wdata   = s_acc_q;
    re      = rd_en_i;
    raddr   = rd_addr_i;
    unique case (state_q)
      KS_IDLE: ;
      KS_LOAD: state_d = KS_INIT;
      KS_INIT: begin
        we = 1'b1;
        if (ti_q == AW'(T - 1)) state_d = KS_MIXR;
      end
      KS_MIXR: begin
        re      = 1'b1;
        raddr   = ti_q;
        state_d = KS_MIXA;
      end
      KS_MIXA: begin
        we      = 1'b1;
        wdata   = a_new;
        state_d = KS_MIXB;
      end
      KS_MIXB: begin
        re      = 1'b1;
        raddr   = ti_next;
        state_d = (step_q == STEP_W'(PASSES - 1)) ? KS_IDLE : KS_MIXA;
      end
      default: state_d = KS_LOAD;
    endcase
    if (kw_i.valid) state_d = KS_LOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= KS_LOAD;
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else begin
      state_q <= state_d;
      if (kw_i.valid) begin
        if (kw_i.high) key_hi_q <= kw_i.data;
        else           key_lo_q <= kw_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q) inside
      KS_IDLE, KS_MIXR: ;
      KS_LOAD: begin
        l_q[0]  <= key_lo_q[rc5_pkg::WORD_W-1:0];
        l_q[1]  <= key_lo_q[rc5_pkg::KEY_W-1:rc5_pkg::WORD_W];
        l_q[2]  <= key_hi_q[rc5_pkg::WORD_W-1:0];
        l_q[3]  <= key_hi_q[rc5_pkg::KEY_W-1:rc5_pkg::WORD_W];
        ti_q    <= '0;
        li_q    <= '0;
        step_q  <= '0;
        ka_q    <= '0;
        kb_q    <= '0;
        s_acc_q <= rc5_pkg::MAGIC_P;
      end
      KS_INIT: begin
        s_acc_q <= s_acc_q + rc5_pkg::MAGIC_Q;
        ti_q    <= ti_next;
      end
      KS_MIXA: ka_q <= a_new;
      KS_MIXB: begin
        kb_q       <= b_new;
        l_q[li_q]  <= b_new;
        li_q       <= li_q + rc5_pkg::LI_W'(1);
        ti_q       <= ti_next;
        step_q     <= step_q + STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

endmodule
